// File: src/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

    // fixed field widths
    localparam int ID_BITS      = 16;
    localparam int DELAY_BITS   = 24;
    localparam int KIND_BITS    = 2;
    localparam int IN_DATA_BITS = ID_BITS + DELAY_BITS;

    // operation codes on s_tuser
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds on m_tuser
    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADDED    = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    // one result beat handed to the output register
    typedef struct packed {
        logic               load;
        kind_t              kind;
        logic [ID_BITS-1:0] id;
        logic               last;
    } out_beat_t;

endpackage

`default_nettype wire

// File: src/deadline_timer_queue.sv
// Channel  | Signals                              | Contents
// ---------+--------------------------------------+---------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser    | tdata: timer_id, delay_ticks; tuser: op
// output   | m_tvalid m_tready m_tdata m_tuser    | tdata: expired_id; tuser: kind;
//          | m_tlast                              | tlast: last
//
// An add writes the slot at the fill count and puts the result into the output register, so
// adds can follow back to back while results drain.
// A tick walks the timer memory one entry per cycle (one read port) while the output side
// takes the expired beats; an expired beat that the output side holds back stalls the walk.
// Expired timers are reported one beat late so the final one can carry tlast.
// Reset clears the tick count and fill count; the memory needs no clearing.
`default_nettype none

module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [IN_DATA_BITS-1:0] s_tdata,   // timer_id [15:0], delay_ticks [39:16]
    input  wire logic                    s_tuser,   // operation
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [ID_BITS-1:0]           m_tdata,   // expired_id
    output logic [KIND_BITS-1:0]         m_tuser,   // kind
    output logic                         m_tlast
);

    localparam int IDX_W   = $clog2(NUM_TIMERS);
    localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
    localparam int ENTRY_W = ID_BITS + TIME_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     keep_reg, keep_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_BITS-1:0]   pend_id_reg, pend_id_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 rd_en;
    logic [ENTRY_W-1:0]   rd_data;

    logic [TIME_BITS-1:0] rd_deadline;
    logic [ID_BITS-1:0]   rd_id;
    logic [TIME_BITS-1:0] diff;
    logic                 passed;
    logic                 stall;
    logic                 accept;
    logic                 out_free;
    logic                 full;
    logic [ID_BITS-1:0]   in_id;
    logic [DELAY_BITS-1:0] in_delay;
    out_beat_t            beat;

    assign in_id    = s_tdata[ID_BITS-1:0];
    assign in_delay = s_tdata[IN_DATA_BITS-1:ID_BITS];
    assign full     = (count_reg == CNT_W'(NUM_TIMERS));

    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // serial-number compare of the entry just read against the advanced tick count
    assign rd_deadline = rd_data[TIME_BITS-1:0];
    assign rd_id       = rd_data[TIME_BITS +: ID_BITS];
    assign diff        = now_reg - rd_deadline;
    assign passed      = (diff != '0) && !diff[TIME_BITS-1];

    // hold the walk when a held expiry must go out and the output is busy
    assign stall = rd_pend_reg && passed && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        keep_next       = keep_reg;
        rd_pend_next    = rd_pend_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = {in_id, now_reg + TIME_BITS'(in_delay)};
        rd_en           = 1'b0;
        beat            = '{load: 1'b0, kind: KIND_ADDED, id: in_id, last: 1'b1};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_ADD)
                    begin
                        // store or reject the new timer
                        beat.load = 1'b1;
                        if (full)
                        begin
                            beat.kind = KIND_REJECTED;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // advance time and start the walk
                        now_next        = now_reg + 1'b1;
                        scan_idx_next   = '0;
                        keep_next       = '0;
                        rd_pend_next    = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    // settle the entry returned by the previous read
                    if (rd_pend_reg)
                    begin
                        if (passed)
                        begin
                            if (pend_valid_reg)
                            begin
                                beat.load = 1'b1;
                                beat.kind = KIND_EXPIRED;
                                beat.id   = pend_id_reg;
                                beat.last = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = rd_id;
                        end
                        else
                        begin
                            // compact survivors toward the front
                            wr_en     = 1'b1;
                            wr_addr   = keep_reg[IDX_W-1:0];
                            wr_data   = rd_data;
                            keep_next = keep_reg + 1'b1;
                        end
                    end
                    // issue the next read, or finish
                    if (scan_idx_reg != count_reg)
                    begin
                        rd_en         = 1'b1;
                        scan_idx_next = scan_idx_reg + 1'b1;
                        rd_pend_next  = 1'b1;
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        if (!rd_pend_reg)
                        begin
                            count_next = keep_reg;
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end

            ST_FLUSH:
            begin
                // send the final expiry with tlast
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    beat.load       = 1'b1;
                    beat.kind       = KIND_EXPIRED;
                    beat.id         = pend_id_reg;
                    beat.last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            keep_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            keep_reg       <= keep_next;
            rd_pend_reg    <= rd_pend_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
    end

    dtq_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (NUM_TIMERS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    dtq_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: src/dtq_ram.sv
`default_nettype none

module dtq_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 16
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/dtq_out.sv
`default_nettype none

module dtq_out
    import dtq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire out_beat_t          beat,
    output logic                    free,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [ID_BITS-1:0]      m_tdata,   // expired_id
    output logic [KIND_BITS-1:0]    m_tuser,   // kind
    output logic                    m_tlast
);

    logic                valid_reg, valid_next;
    kind_t               kind_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic                last_reg;

    // register can take a beat when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (beat.load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, loaded only when free
    always_ff @(posedge clk)
    begin
        if (beat.load)
        begin
            kind_reg <= beat.kind;
            id_reg   <= beat.id;
            last_reg <= beat.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = id_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: src/dtq_checker.sv
`default_nettype none

module dtq_checker
    import dtq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [IN_DATA_BITS-1:0] s_tdata,
    input  wire logic                    s_tuser,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [ID_BITS-1:0]      m_tdata,
    input  wire logic [KIND_BITS-1:0]    m_tuser,
    input  wire logic                    m_tlast
);

    // an add answers on the next cycle with its own id and tlast
    a_add_reply: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_ADD) |=>
        m_tvalid && m_tlast && (m_tdata == $past(s_tdata[ID_BITS-1:0])) &&
        ((m_tuser == KIND_ADDED) || (m_tuser == KIND_REJECTED)))
        else $error("add beat not answered next cycle");

    // add results are single-beat
    a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_EXPIRED) |-> m_tlast)
        else $error("add result without tlast");

    // no undefined kind code
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_ADDED) || (m_tuser == KIND_REJECTED) ||
                      (m_tuser == KIND_EXPIRED)))
        else $error("undefined result kind");

    // a tick blocks further input while the table is walked
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_TICK) |=> !s_tready)
        else $error("input taken during tick walk");

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("output beat changed while stalled");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/deadline_timer_queue_tb.sv
`default_nettype none

module deadline_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dtq_pkg::*;

    localparam int NUM_TIMERS      = 16;
    localparam int TIME_BITS       = 32;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TIMEOUT_NS      = 5_000_000;
    localparam int MAX_REPORTS     = 10;

    // how a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ONE,
        CHK_NONE
    } check_t;

    typedef struct packed {
        logic                  op;
        logic [ID_BITS-1:0]    id;
        logic [DELAY_BITS-1:0] delay;
        check_t                chk;
        kind_t                 kind;
    } step_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_BITS-1:0] id;
        logic               last;
    } timer_beat_t;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata  = '0;   // timer_id [15:0], delay_ticks [39:16]
    logic                    s_tuser  = OP_ADD; // operation
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [ID_BITS-1:0]      m_tdata;         // expired_id
    logic [KIND_BITS-1:0]    m_tuser;         // kind
    logic                    m_tlast;

    // check mode travels beside the beat it belongs to
    check_t step_check = CHK_MODEL;
    kind_t  step_kind  = KIND_ADDED;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  mismatches  = 0;
    logic hold_req   = 1'b0;
    logic hold_seen  = 1'b0;
    int  hold_left   = 0;

    // timer table mirror
    logic [TIME_BITS-1:0] now_tick = '0;
    logic [ID_BITS-1:0]   timer_ids [NUM_TIMERS];
    logic [TIME_BITS-1:0] timer_deadlines [NUM_TIMERS];
    int                   timers_held = 0;
    timer_beat_t          fresh_beats[$];
    timer_beat_t          awaited_beats[$];

    deadline_timer_queue #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // apply one add or tick to the mirror, leave its beats in fresh_beats
    function automatic void apply_timer_step(logic op, logic [ID_BITS-1:0] id,
                                             logic [DELAY_BITS-1:0] delay);
        int                   kept;
        int                   fired;
        logic [TIME_BITS-1:0] age;
        kept  = 0;
        fired = 0;
        if (op == OP_ADD)
        begin
            if (timers_held >= NUM_TIMERS)
            begin
                fresh_beats.insert(fresh_beats.size(),
                                   timer_beat_t'{KIND_REJECTED, id, 1'b1});
            end
            else
            begin
                timer_ids[timers_held]       = id;
                timer_deadlines[timers_held] = now_tick + TIME_BITS'(delay);
                timers_held++;
                fresh_beats.insert(fresh_beats.size(), timer_beat_t'{KIND_ADDED, id, 1'b1});
            end
        end
        else
        begin
            now_tick = now_tick + 1'b1;
            // serial-number compare: passed when the age is nonzero and not negative
            for (int i = 0; i < timers_held; i++)
            begin
                age = now_tick - timer_deadlines[i];
                if (age != '0 && !age[TIME_BITS-1])
                begin
                    fresh_beats.insert(fresh_beats.size(),
                                       timer_beat_t'{KIND_EXPIRED, timer_ids[i], 1'b0});
                    fired++;
                end
                else
                begin
                    timer_ids[kept]       = timer_ids[i];
                    timer_deadlines[kept] = timer_deadlines[i];
                    kept++;
                end
            end
            timers_held = kept;
            if (fired > 0)
                fresh_beats[fresh_beats.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void report_mismatch(string what, timer_beat_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected kind %0d id %h last %b, got kind %0d id %h last %b",
                     $realtime, what, want.kind, want.id, want.last, m_tuser, m_tdata, m_tlast);
    endfunction

    // check result beats against the oldest expectation, then predict accepted beats
    always @(posedge clk)
    begin
        timer_beat_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_beats.size() == 0)
                    report_mismatch("unexpected result", '{KIND_ADDED, '0, 1'b0});
                else
                begin
                    want = awaited_beats.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== want.id || m_tlast !== want.last)
                        report_mismatch("wrong result", want);
                end
            end
            if (s_tvalid && s_tready)
            begin
                fresh_beats.delete();
                apply_timer_step(s_tuser, s_tdata[ID_BITS-1:0],
                                 s_tdata[IN_DATA_BITS-1:ID_BITS]);
                case (step_check)
                    CHK_ONE:  awaited_beats.insert(awaited_beats.size(),
                                  timer_beat_t'{step_kind, s_tdata[ID_BITS-1:0], 1'b1});
                    CHK_NONE: ;
                    default:  foreach (fresh_beats[i])
                                  awaited_beats.insert(awaited_beats.size(), fresh_beats[i]);
                endcase
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // offer one beat, with random gaps ahead of it, and hold it until taken
    task automatic offer(step_t st);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= st.op;
        s_tdata    <= {st.delay, st.id};
        step_check <= st.chk;
        step_kind  <= st.kind;
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending until every expected result has come, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (awaited_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        step_t plan[$];
        step_t st;
        int    add_pct;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: empty tick, extreme ids and delays, fill, reject, expiries
        plan.insert(plan.size(), step_t'{OP_TICK, 16'h0000, 24'h000000, CHK_NONE, KIND_ADDED});
        plan.insert(plan.size(), step_t'{OP_ADD,  16'hFFFF, 24'hFFFFFF, CHK_ONE,  KIND_ADDED});
        plan.insert(plan.size(), step_t'{OP_ADD,  16'h0000, 24'h000000, CHK_ONE,  KIND_ADDED});
        plan.insert(plan.size(), step_t'{OP_TICK, 16'h0000, 24'h000000, CHK_MODEL, KIND_ADDED});
        for (int k = 0; k < NUM_TIMERS - 1; k++)
            plan.insert(plan.size(),
                        step_t'{OP_ADD, ID_BITS'(16'h1000 + k), DELAY_BITS'((k * 3) % 7),
                                CHK_ONE, KIND_ADDED});
        plan.insert(plan.size(), step_t'{OP_ADD,  16'hBEEF, 24'h000005, CHK_ONE, KIND_REJECTED});
        plan.insert(plan.size(), step_t'{OP_TICK, 16'h0000, 24'h000000, CHK_MODEL, KIND_ADDED});
        plan.insert(plan.size(), step_t'{OP_TICK, 16'h0000, 24'h000000, CHK_MODEL, KIND_ADDED});
        // tick with all data bits set: the fields must be ignored
        plan.insert(plan.size(), step_t'{OP_TICK, 16'hFFFF, 24'hFFFFFF, CHK_MODEL, KIND_ADDED});
        plan.insert(plan.size(), step_t'{OP_TICK, 16'h0000, 24'h000000, CHK_MODEL, KIND_ADDED});
        foreach (plan[i])
            offer(plan[i]);
        drain();

        // random phases: both sides idle, then swapped, then neither
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 48 : 0;
            rx_idle_pct <= (phase == 0) ? 48 : (phase == 1) ? 38 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 2 && n == 10)
                    hold_req <= ~hold_req;
                // bursts of adds push the table to full
                add_pct = ((n % 40) < 10) ? 90 : 45;
                st.op   = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
                st.id   = ID_BITS'($urandom);
                if (st.op == OP_TICK)
                    st.delay = DELAY_BITS'($urandom);
                else if ($urandom_range(0, 9) == 0)
                    st.delay = DELAY_BITS'($urandom_range(4, 40));
                else
                    st.delay = DELAY_BITS'($urandom_range(0, 3));
                st.chk  = CHK_MODEL;
                st.kind = KIND_ADDED;
                offer(st);
            end
            drain();
        end

        if (mismatches == 0 && awaited_beats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/dtq_pkg.sv
src/dtq_ram.sv
src/dtq_out.sv
src/deadline_timer_queue.sv
src/dtq_checker.sv
test/deadline_timer_queue_tb.sv
